@@ rtl/clmm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clmm_pkg
// Shared constants and types of the cavity local maximum marker.
// ----------------------------------------------------------------------------
package clmm_pkg;

  localparam int MAX_SIDE = 32;
  localparam int COL_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W   = 6;
  localparam int DEPTH_W  = 4;

  typedef logic [COL_W-1:0]   col_t;
  typedef logic [SIDE_W-1:0]  side_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  // requests into the line store
  typedef struct packed {
    logic   rd_en;
    col_t   rd_addr;
    col_t   rd_next_addr;
    logic   wr_cur_en;
    col_t   wr_cur_addr;
    depth_t wr_cur_data;
    logic   wr_prev_en;
    col_t   wr_prev_addr;
    depth_t wr_prev_data;
  } line_req_t;

  // registered read data of the line store
  typedef struct packed {
    depth_t centre;
    depth_t right;
    depth_t up;
  } line_rsp_t;

endpackage

@@ rtl/cavity_local_maximum_marker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cavity_local_maximum_marker_core
// Four-neighbour strict local maximum marker over a square depth grid.
// ----------------------------------------------------------------------------
// Cells enter in raster order at one per clock while cell_stall is low; each
// cell from row two on releases the cell one row above it through s1 and the
// output register. The final cell of a grid also releases the whole last row:
// the line memory is read back one column per cycle unless the output stalls,
// the input stalls until that read-back ends, and the grid ends with up to
// grid_side+1 result beats. Storage is two row memories of 32 depths; no
// clearing pass is needed after reset. Write grid_side only while idle; it restarts the grid.
// ----------------------------------------------------------------------------
module cavity_local_maximum_marker_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  clmm_pkg::side_t        cfg_wdata,
  input  logic                   cell_valid,
  output logic                   cell_stall,
  input  clmm_pkg::depth_t       cell_depth,
  output logic                   result_valid,
  input  logic                   result_stall,
  output clmm_pkg::depth_t       out_depth,
  output logic                   is_cavity,
  output logic                   last_of_grid
);

  typedef struct packed {
    logic             is_item;
    logic             emit;
    logic             cav_ok;
    logic             last_out;
    clmm_pkg::col_t   col;
    clmm_pkg::depth_t below;
  } s1_t;

  clmm_pkg::col_t      side_m1;
  clmm_pkg::col_t      row;
  clmm_pkg::col_t      col;
  clmm_pkg::col_t      flush_col;
  logic                flush_active;
  logic                s1_valid;
  s1_t                 s1;
  s1_t                 s1_next;
  clmm_pkg::depth_t    left;
  clmm_pkg::line_req_t req;
  clmm_pkg::line_rsp_t rsp;

  logic accept;
  logic inject;
  logic issue;
  logic out_load;
  logic s1_adv;
  logic s1_free;
  logic at_last;
  logic cav;
  clmm_pkg::side_t side_eff;

  clmm_line_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    if (cfg_wdata == '0) begin
      side_eff = clmm_pkg::side_t'(1);
    end else if (cfg_wdata > clmm_pkg::side_t'(clmm_pkg::MAX_SIDE)) begin
      side_eff = clmm_pkg::side_t'(clmm_pkg::MAX_SIDE);
    end else begin
      side_eff = cfg_wdata;
    end
  end

  assign out_load   = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && (!s1.emit || out_load);
  assign s1_free    = !s1_valid || s1_adv;
  assign cell_stall = flush_active || !s1_free;
  assign accept     = cell_valid && !cell_stall;
  assign inject     = flush_active && s1_free;
  assign issue      = accept || inject;
  assign at_last    = (row == side_m1) && (col == side_m1);

  always_comb begin
    req              = '0;
    req.rd_en        = issue;
    req.rd_addr      = flush_active ? flush_col : col;
    req.rd_next_addr = col + clmm_pkg::col_t'(1);
    req.wr_cur_en    = accept;
    req.wr_cur_addr  = col;
    req.wr_cur_data  = cell_depth;
    req.wr_prev_en   = s1_adv && s1.is_item;
    req.wr_prev_addr = s1.col;
    req.wr_prev_data = rsp.centre;
  end

  always_comb begin
    s1_next = '0;
    if (flush_active) begin
      s1_next.emit     = 1'b1;
      s1_next.last_out = (flush_col == side_m1);
    end else begin
      s1_next.is_item = 1'b1;
      s1_next.emit    = (row != '0);
      s1_next.cav_ok  = (row > clmm_pkg::col_t'(1)) && (col != '0) && (col < side_m1);
      s1_next.col     = col;
      s1_next.below   = cell_depth;
    end
  end

  assign cav = s1.cav_ok && (left < rsp.centre) && (rsp.right < rsp.centre)
               && (rsp.up < rsp.centre) && (s1.below < rsp.centre);

  always_ff @(posedge clk) begin
    if (rst) begin
      side_m1      <= clmm_pkg::col_t'(clmm_pkg::MAX_SIDE - 1);
      row          <= '0;
      col          <= '0;
      flush_active <= 1'b0;
      flush_col    <= '0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        side_m1 <= clmm_pkg::col_t'(side_eff - clmm_pkg::side_t'(1));
        row     <= '0;
        col     <= '0;
      end else if (accept) begin
        if (at_last) begin
          row <= '0;
          col <= '0;
        end else if (col == side_m1) begin
          row <= row + clmm_pkg::col_t'(1);
          col <= '0;
        end else begin
          col <= col + clmm_pkg::col_t'(1);
        end
      end

      if (accept && at_last) begin
        flush_active <= 1'b1;
        flush_col    <= '0;
      end else if (inject) begin
        if (flush_col == side_m1) begin
          flush_active <= 1'b0;
          flush_col    <= '0;
        end else begin
          flush_col <= flush_col + clmm_pkg::col_t'(1);
        end
      end

      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (out_load) begin
        result_valid <= s1_valid && s1.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1 <= s1_next;
    end
    if (s1_adv && s1.is_item) begin
      left <= rsp.centre;
    end
    if (out_load && s1_valid && s1.emit) begin
      out_depth    <= rsp.centre;
      is_cavity    <= cav;
      last_of_grid <= s1.last_out;
    end
  end

  a_last_starts_flush: assert property (@(posedge clk) disable iff (rst)
    accept && at_last |=> flush_active)
    else $error("flush did not start after the last cell");

  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    inject && (flush_col == side_m1) |=> !flush_active)
    else $error("flush did not end on the last column");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && !$past(issue) && (rsp === $past(rsp)))
    else $error("line store data lost while a beat waits");

endmodule

@@ rtl/clmm_line_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clmm_line_store
// Two row memories: the row above the current input and the row above that.
// Read first, with registered read data; read data holds between reads.
// ----------------------------------------------------------------------------
module clmm_line_store (
  input  logic                clk,
  input  clmm_pkg::line_req_t req,
  output clmm_pkg::line_rsp_t rsp
);

  clmm_pkg::depth_t cur_row  [clmm_pkg::MAX_SIDE];
  clmm_pkg::depth_t prev_row [clmm_pkg::MAX_SIDE];

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rsp.centre <= cur_row[req.rd_addr];
      rsp.right  <= cur_row[req.rd_next_addr];
      rsp.up     <= prev_row[req.rd_addr];
    end
    if (req.wr_cur_en) begin
      cur_row[req.wr_cur_addr] <= req.wr_cur_data;
    end
    if (req.wr_prev_en) begin
      prev_row[req.wr_prev_addr] <= req.wr_prev_data;
    end
  end

endmodule
